// ----- rtl/jel_pkg.sv -----
// Shared types and constants for the JPEG Exif segment locator.
package jel_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SOI   = 3'd1,
    PH_MARK  = 3'd2,
    PH_FILL  = 3'd3,
    PH_LENHI = 3'd4,
    PH_LENLO = 3'd5,
    PH_SIG   = 3'd6,
    PH_SKIP  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_NONE  = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] payload_offset;
    logic [15:0] payload_length;
  } result_t;

  localparam logic [7:0] MK_FILL   = 8'hFF;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_SOS    = 8'hDA;
  localparam logic [7:0] MK_TEM    = 8'h01;
  localparam logic [7:0] MK_RST_LO = 8'hD0;
  localparam logic [7:0] MK_RST_HI = 8'hD7;
  localparam logic [7:0] MK_APP1   = 8'hE1;

  localparam logic [2:0] SIG_LAST  = 3'd5;
  localparam int unsigned SIG_LEN  = 6;

  // "Exif\0\0"
  function automatic logic [7:0] exif_sig(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h45;
      3'd1:    v = 8'h78;
      3'd2:    v = 8'h69;
      3'd3:    v = 8'h66;
      3'd4:    v = 8'h00;
      3'd5:    v = 8'h00;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/jel_if.sv -----
// Stream interfaces for the byte input and the result output.
interface jel_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        start_req;
  logic [31:0] total_length;

  modport source (output valid, output data_byte, output start_req, output total_length,
                  input ready);
  modport sink   (input valid, input data_byte, input start_req, input total_length,
                  output ready);
endinterface

interface jel_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] payload_offset;
  logic [15:0] payload_length;

  modport source (output valid, output status, output payload_offset,
                  output payload_length, input ready);
  modport sink   (input valid, input status, input payload_offset,
                  input payload_length, output ready);
endinterface

// ----- rtl/jel_parser.sv -----
// Marker segment walker: parse state registers and the per-byte update.
module jel_parser import jel_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        beat,
  input  logic [7:0]  data_byte,
  input  logic        start_req,
  input  logic [31:0] total_length,
  output logic        res_valid,
  output result_t     res
);

  localparam int LB = LENGTH_BITS;
  localparam int XB = LB + 3;
  localparam int WB = (LB > 32) ? LB : 32;

  phase_t          phase_r, phase_nxt;
  logic [LB-1:0]   pos_r, pos_nxt;
  logic [LB-1:0]   flen_r, flen_nxt;
  logic [7:0]      marker_r, marker_nxt;
  logic [7:0]      lenhi_r, lenhi_nxt;
  logic [15:0]     segrem_r, segrem_nxt;
  logic [2:0]      sigidx_r, sigidx_nxt;
  logic            decided_r, decided_nxt;

  logic [WB-1:0]   tl_w, lmax_w, off_w;
  logic [LB-1:0]   flen_sat;
  logic [XB-1:0]   p_x, fl_x;
  logic [15:0]     seg, pay, rem;
  logic            next_over;   // a marker and its length field starting at p+1 cannot fit
  logic            standalone;  // TEM or RSTn, no length field
  logic            len_bad;
  logic            sig_seg;     // APP1 long enough to hold the Exif header
  logic            sig_hit;

  always_comb begin
    tl_w     = WB'(total_length);
    lmax_w   = WB'({LB{1'b1}});
    flen_sat = (tl_w > lmax_w) ? lmax_w[LB-1:0] : tl_w[LB-1:0];
    p_x      = XB'(pos_r);
    fl_x     = XB'(flen_r);
    seg      = {lenhi_r, data_byte};
    pay      = seg - 16'd2;
    rem      = segrem_r - 16'd1;
    off_w    = WB'(pos_r - LB'(5));
    next_over = (p_x + XB'(5)) > fl_x;
    standalone = (data_byte == MK_TEM) ||
                 ((data_byte >= MK_RST_LO) && (data_byte <= MK_RST_HI));
    len_bad  = (seg < 16'd2) || ((XB'(seg) + p_x - XB'(1)) > fl_x);
    sig_seg  = (marker_r == MK_APP1) && (pay >= 16'(SIG_LEN));
    sig_hit  = (data_byte == exif_sig(sigidx_r));
  end

  // result decode
  always_comb begin
    res_valid = 1'b0;
    res       = '{status: ST_NONE, payload_offset: '0, payload_length: '0};

    if (beat) begin
      if (start_req) begin
        if ((flen_sat < LB'(4)) || (data_byte != MK_FILL)) begin
          res_valid  = 1'b1;
          res.status = ST_BAD;
        end
      end else if (!decided_r) begin
        case (phase_r)
          PH_SOI: begin
            if (data_byte != MK_SOI) begin
              res_valid  = 1'b1;
              res.status = ST_BAD;
            end else if (fl_x < XB'(6)) begin
              res_valid  = 1'b1;
              res.status = ST_NONE;
            end
          end
          PH_MARK: begin
            if ((data_byte != MK_FILL) || ((p_x + XB'(1)) >= fl_x)) begin
              res_valid  = 1'b1;
              res.status = ST_BAD;
            end
          end
          PH_FILL: begin
            if (data_byte == MK_FILL) begin
              if ((p_x + XB'(1)) >= fl_x) begin
                res_valid  = 1'b1;
                res.status = ST_BAD;
              end
            end else if ((data_byte == MK_EOI) || (data_byte == MK_SOS)) begin
              res_valid  = 1'b1;
              res.status = ST_NONE;
            end else if (standalone) begin
              if (next_over) begin
                res_valid  = 1'b1;
                res.status = ST_NONE;
              end
            end else if ((p_x + XB'(3)) > fl_x) begin
              res_valid  = 1'b1;
              res.status = ST_BAD;
            end
          end
          PH_LENLO: begin
            if (len_bad) begin
              res_valid  = 1'b1;
              res.status = ST_BAD;
            end else if (!sig_seg && (pay == 16'd0) && next_over) begin
              res_valid  = 1'b1;
              res.status = ST_NONE;
            end
          end
          PH_SIG: begin
            if (sig_hit) begin
              if (sigidx_r == SIG_LAST) begin
                res_valid          = 1'b1;
                res.status         = ST_FOUND;
                res.payload_offset = off_w[31:0];
                res.payload_length = rem + 16'(SIG_LEN);
              end
            end else if ((rem == 16'd0) && next_over) begin
              res_valid  = 1'b1;
              res.status = ST_NONE;
            end
          end
          PH_SKIP: begin
            if ((rem == 16'd0) && next_over) begin
              res_valid  = 1'b1;
              res.status = ST_NONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // next state; a result always drops back to idle
  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    flen_nxt    = flen_r;
    marker_nxt  = marker_r;
    lenhi_nxt   = lenhi_r;
    segrem_nxt  = segrem_r;
    sigidx_nxt  = sigidx_r;
    decided_nxt = decided_r;

    if (beat) begin
      if (start_req) begin
        flen_nxt    = flen_sat;
        pos_nxt     = LB'(1);
        marker_nxt  = '0;
        lenhi_nxt   = '0;
        segrem_nxt  = '0;
        sigidx_nxt  = '0;
        decided_nxt = 1'b0;
        phase_nxt   = PH_SOI;
      end else if (!decided_r) begin
        pos_nxt = pos_r + LB'(1);
        case (phase_r)
          PH_SOI: begin
            phase_nxt = PH_MARK;
          end
          PH_MARK: begin
            phase_nxt = PH_FILL;
          end
          PH_FILL: begin
            if (data_byte != MK_FILL) begin
              marker_nxt = data_byte;
              phase_nxt  = standalone ? PH_MARK : PH_LENHI;
            end
          end
          PH_LENHI: begin
            lenhi_nxt = data_byte;
            phase_nxt = PH_LENLO;
          end
          PH_LENLO: begin
            segrem_nxt = pay;
            if (sig_seg) begin
              sigidx_nxt = '0;
              phase_nxt  = PH_SIG;
            end else if (pay == 16'd0) begin
              phase_nxt = PH_MARK;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
          PH_SIG: begin
            segrem_nxt = rem;
            if (sig_hit) begin
              sigidx_nxt = sigidx_r + 3'd1;
            end else if (rem == 16'd0) begin
              phase_nxt = PH_MARK;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
          PH_SKIP: begin
            segrem_nxt = rem;
            if (rem == 16'd0) begin
              phase_nxt = PH_MARK;
            end
          end
          default: begin
            decided_nxt = 1'b1;
            phase_nxt   = PH_IDLE;
          end
        endcase
      end
      if (res_valid) begin
        decided_nxt = 1'b1;
        phase_nxt   = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      pos_r     <= '0;
      flen_r    <= '0;
      marker_r  <= '0;
      lenhi_r   <= '0;
      segrem_r  <= '0;
      sigidx_r  <= '0;
      decided_r <= 1'b1;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      flen_r    <= flen_nxt;
      marker_r  <= marker_nxt;
      lenhi_r   <= lenhi_nxt;
      segrem_r  <= segrem_nxt;
      sigidx_r  <= sigidx_nxt;
      decided_r <= decided_nxt;
    end
  end

endmodule

// ----- rtl/jpeg_exif_segment_locator.sv -----
// Top level of the JPEG Exif segment locator: byte intake and result register.
//
//   channel   dir   content                                   beat
//   in_bus    in    data_byte, start_req, total_length         valid & ready
//   out_bus   out   status, payload_offset, payload_length     valid & ready
//
// One byte per cycle: each beat updates the parse registers in the same cycle.
// The result register loads on the beat of the deciding byte; valid the next cycle.
// in_bus.ready drops only while a result is held and out_bus.ready is low.
// Synchronous active-low reset leaves the block idle until a start beat.
module jpeg_exif_segment_locator import jel_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  jel_in_if.sink     in_bus,
  jel_out_if.source  out_bus
);

  logic    beat;
  logic    res_valid;
  result_t res;
  logic    out_valid_r, out_valid_nxt;
  result_t out_r;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign beat         = in_bus.valid && in_bus.ready;

  jel_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat         (beat),
    .data_byte    (in_bus.data_byte),
    .start_req    (in_bus.start_req),
    .total_length (in_bus.total_length),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.status         = out_r.status;
  assign out_bus.payload_offset = out_r.payload_offset;
  assign out_bus.payload_length = out_r.payload_length;

endmodule

// ----- rtl/jel_checker.sv -----
// Port-level assertions for the Exif segment locator, bound to the top level.
module jel_checker import jel_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_offset,
  input logic [15:0] out_length
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_offset) && $stable(out_length))
    else $error("result changed while stalled");

  // every new result follows an accepted byte
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without input beat");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_FOUND) |-> (out_offset == 32'd0) && (out_length == 16'd0))
    else $error("offset or length set on a miss");

  // smallest hit: FF D8 FF E1 len len then six signature bytes
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FOUND) |-> (out_offset >= 32'd6) && (out_length >= 16'd6))
    else $error("found result out of range");

  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind jpeg_exif_segment_locator jel_checker u_jel_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_status (out_bus.status),
  .out_offset (out_bus.payload_offset),
  .out_length (out_bus.payload_length)
);
